/* rtl/kmsd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the keypad matrix scanner and debouncer.
package kmsd_pkg;

  localparam int unsigned ROW_COUNT = 4;
  localparam int unsigned COL_COUNT = 3;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd4;
  localparam logic [7:0] COUNT_MAX       = 8'hff;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_PRESS_THRESHOLD = 1'b0;

  typedef struct packed {
    logic       opcode;
    logic [2:0] column_levels;
  } in_t;

  typedef struct packed {
    logic [1:0] drive_row;
    logic [3:0] key_code;
  } out_t;

  typedef struct packed {
    logic [1:0] scan_row;
    logic [3:0] candidate_key;
    logic [7:0] stable_count;
    logic [3:0] latched_key;
  } scan_state_t;

endpackage

/* rtl/kmsd_col_step.sv */
`timescale 1ns / 1ps
// Debounce update for one column of the driven row.
module kmsd_col_step (
  input  kmsd_pkg::scan_state_t st_in,
  input  logic [3:0]            code,
  input  logic                  pressed,
  output kmsd_pkg::scan_state_t st_out
);
  import kmsd_pkg::*;

  always_comb begin
    st_out = st_in;
    if (pressed) begin
      if (st_in.candidate_key == code) begin
        if (st_in.stable_count != COUNT_MAX) begin
          st_out.stable_count = st_in.stable_count + 8'd1;
        end
      end else begin
        st_out.candidate_key = code;
        st_out.stable_count  = '0;
      end
    end else if (st_in.latched_key == code) begin
      st_out.stable_count = '0;
      st_out.latched_key  = '0;
    end
  end

endmodule

/* rtl/kmsd_apb_regs.sv */
`timescale 1ns / 1ps
// APB-style register port holding the press threshold.
module kmsd_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kmsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [7:0]                   press_threshold
);
  import kmsd_pkg::*;

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_PRESS_THRESHOLD);
  assign prdata  = reg_sel ? {24'd0, press_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      press_threshold <= pwdata[7:0];
    end
  end

endmodule

/* rtl/kmsd_core.sv */
`timescale 1ns / 1ps
// Scan state registers with the per-transaction tick and read update.
module kmsd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  kmsd_pkg::in_t         item,
  input  logic [7:0]            press_threshold,
  output kmsd_pkg::out_t        result_next,
  output kmsd_pkg::scan_state_t state
);
  import kmsd_pkg::*;

  scan_state_t chain [COL_COUNT+1];
  scan_state_t tick_state;
  scan_state_t read_state;
  scan_state_t state_next;
  logic [3:0]  row_base;
  logic        report;

  assign row_base = {1'b0, state.scan_row, 1'b0} + {2'b00, state.scan_row};
  assign chain[0] = state;

  for (genvar c = 0; c < COL_COUNT; c++) begin : g_col
    localparam logic [3:0] COL_OFS = 4'(c + 1);
    kmsd_col_step u_step (
      .st_in   (chain[c]),
      .code    (row_base + COL_OFS),
      .pressed (~item.column_levels[c]),
      .st_out  (chain[c+1])
    );
  end

  assign report = (state.stable_count > press_threshold) && (state.latched_key == 4'd0);

  always_comb begin
    tick_state          = chain[COL_COUNT];
    tick_state.scan_row = state.scan_row + 2'd1;
    read_state          = state;
    if (report) begin
      read_state.latched_key   = state.candidate_key;
      read_state.candidate_key = '0;
    end
  end

  always_comb begin
    unique case (item.opcode)
      OP_TICK: begin
        state_next           = tick_state;
        result_next.key_code = '0;
      end
      OP_READ: begin
        state_next           = read_state;
        result_next.key_code = report ? state.candidate_key : 4'd0;
      end
      default: begin
        state_next           = state;
        result_next.key_code = '0;
      end
    endcase
    result_next.drive_row = state_next.scan_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

/* rtl/keypad_matrix_scan_debounce_top.sv */
`timescale 1ns / 1ps
// Top level of the 4x3 keypad matrix scanner and debouncer.
// For each transaction, the debounce state updates at the edge
// that accepts the item, and its result lands in an output register, with a
// one-entry skid stage behind it, so an item can be accepted every cycle while
// the consumer keeps up and one more while a result waits. A tick carries the
// active-low column levels of the row named by the previous drive_row; a read
// returns the debounced key code (1..12) once, or 0. The press threshold sits
// at byte address 0 of the register port and resets to 4.
module keypad_matrix_scan_debounce_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  kmsd_pkg::in_t                item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output kmsd_pkg::out_t               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kmsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import kmsd_pkg::*;

  logic        accept;
  logic        take_out;
  logic [7:0]  press_threshold;
  out_t        result_next;
  out_t        skid;
  logic        skid_valid;
  scan_state_t state;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take_out   = result_valid && !result_stall;

  kmsd_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .press_threshold (press_threshold)
  );

  kmsd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .item            (item),
    .press_threshold (press_threshold),
    .result_next     (result_next),
    .state           (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (accept) begin
      if (!result_valid || take_out) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take_out) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!result_valid || take_out) begin
        result <= result_next;
      end else begin
        skid <= result_next;
      end
    end else if (take_out) begin
      result <= skid;
    end
  end

`ifndef SYNTH
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without an output entry");

  a_key_code_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.key_code <= 4'd12))
    else $error("key code out of range");

  a_report_latches: assert property (@(posedge clk) disable iff (rst)
    (accept && item.opcode == OP_READ && result_next.key_code != 4'd0) |=>
      (state.latched_key == $past(result_next.key_code) && state.candidate_key == 4'd0))
    else $error("reported key not latched");

  a_tick_no_key: assert property (@(posedge clk) disable iff (rst)
    (accept && item.opcode == OP_TICK) |-> (result_next.key_code == 4'd0))
    else $error("tick produced a key code");
`endif

endmodule
